// ===== sv/pressure_pid_with_bias_defines.svh =====
// ----------------------------------------------------------------------------
// Pressure PID assertion macros
// Shared property wrappers for the checker of the pressure PID block.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_PID_WITH_BIAS_DEFINES_SVH
`define PRESSURE_PID_WITH_BIAS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pressure PID check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pressure PID check failed");

`endif

// ===== sv/ppid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure PID package
// Types, register codes and fixed-point constants of the pressure PID block.
// ----------------------------------------------------------------------------
package ppid_pkg;

  localparam int GAIN_W    = 24;
  localparam int TGT_W     = 9;
  localparam int LIM_W     = 15;
  localparam int INTEG_W   = 16;
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_SHIFT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_PROP   = 3'd1,
    REG_INTEG  = 3'd2,
    REG_DERIV  = 3'd3,
    REG_WINDUP = 3'd4
  } reg_idx_e;

  localparam logic [TGT_W-1:0]  TARGET_RST = 9'd100;
  localparam logic [GAIN_W-1:0] PROP_RST   = 24'd167772;
  localparam logic [GAIN_W-1:0] INTEG_RST  = 24'd9060;
  localparam logic [GAIN_W-1:0] DERIV_RST  = 24'd256691;
  localparam logic [LIM_W-1:0]  WINDUP_RST = 15'd100;

  // Bias polynomial in Q32: C0 + C1*t - C2*t*t.
  localparam logic signed [63:0] BIAS_C0 = 64'sd768369649;
  localparam logic [GAIN_W-1:0]  BIAS_C1 = 24'd14270029;
  localparam logic [GAIN_W-1:0]  BIAS_C2 = 24'd18505;

  localparam logic signed [63:0] FLOOR_TEST  = 64'sd343597383;
  localparam logic signed [63:0] CEIL_TEST   = 64'sd4252017623;
  localparam logic [DRIVE_W-1:0] FLOOR_DRIVE = 16'd9830;
  localparam logic [DRIVE_W-1:0] CEIL_DRIVE  = 16'd64881;
  localparam logic [31:0]        ROUND_HALF  = 32'd32768;

  typedef enum logic [2:0] {
    OP_TSQ   = 3'd0,
    OP_PROP  = 3'd1,
    OP_INTEG = 3'd2,
    OP_DERIV = 3'd3,
    OP_BIAS1 = 3'd4,
    OP_BIAS2 = 3'd5
  } mac_op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ERR   = 3'd1,
    ST_INTEG = 3'd2,
    ST_MUL   = 3'd3,
    ST_DRAIN = 3'd4,
    ST_OUT   = 3'd5
  } seq_state_e;

  typedef enum logic [1:0] {
    LIM_NONE  = 2'd0,
    LIM_FLOOR = 2'd1,
    LIM_CEIL  = 2'd2
  } limit_e;

  typedef struct packed {
    logic    clear;
    logic    issue;
    mac_op_e op;
  } mac_ctl_t;

  typedef struct packed {
    logic load_meas;
    logic load_err;
    logic load_integ;
    logic load_out;
  } seq_ctl_t;

endpackage

// ===== sv/pressure_pid_with_bias.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure PID controller with target bias
// PID drive with integrator anti-windup, quadratic target bias and drive limits.
// ----------------------------------------------------------------------------
// One sample goes from acceptance through forming the error, updating the
// clamped integrator, six passes through the single shared 25 x 19 bit
// multiplier (target squared, the three gain terms and the two bias terms),
// adding the last product and applying the floor and ceiling limits, in turn.
// The input is stalled throughout. The result sits in an output register, so
// a new sample is taken while it waits; only a result that is still held when
// the next one is finished delays it.
// Configuration writes are taken at any time, but they must be made only while
// no sample is in flight, as a sample reads the settings over several cycles.
module pressure_pid_with_bias #(
  parameter int PRESSURE_WIDTH = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ppid_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [PRESSURE_WIDTH-1:0]     measured_pressure_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ppid_pkg::DRIVE_W-1:0]         drive_level_o,
  output logic [1:0]                           limit_state_o
);

  localparam int ERR_W  = ((PRESSURE_WIDTH > 10) ? PRESSURE_WIDTH : 10) + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int SUM_W  = ((ppid_pkg::INTEG_W > ERR_W) ? ppid_pkg::INTEG_W : ERR_W) + 1;
  localparam int TSQ_W  = 2 * ppid_pkg::TGT_W;
  localparam int B_W    = (DIFF_W > TSQ_W + 1) ? DIFF_W : TSQ_W + 1;
  localparam int ACC_W  = B_W + 34;

  logic [ppid_pkg::TGT_W-1:0]  target_q;
  logic [ppid_pkg::GAIN_W-1:0] prop_gain_q;
  logic [ppid_pkg::GAIN_W-1:0] integ_gain_q;
  logic [ppid_pkg::GAIN_W-1:0] deriv_gain_q;
  logic [ppid_pkg::LIM_W-1:0]  windup_q;

  logic signed [PRESSURE_WIDTH-1:0]   meas_q;
  logic signed [ERR_W-1:0]            err_d, err_q;
  logic signed [ERR_W-1:0]            prev_q;
  logic signed [DIFF_W-1:0]           diff_d, diff_q;
  logic signed [ppid_pkg::INTEG_W-1:0] integ_q, integ_d;
  logic signed [SUM_W-1:0]            integ_sum, lim_pos, lim_neg;

  ppid_pkg::seq_ctl_t seq;
  ppid_pkg::mac_ctl_t mac_ctl;
  logic               ready;
  logic               out_hold;

  logic signed [ACC_W-1:0]          acc;
  logic signed [63:0]               acc_wide;
  logic [ACC_W-1:0]                 acc_rnd;
  logic [ppid_pkg::DRIVE_W-1:0]     drive_d, drive_q;
  ppid_pkg::limit_e                 limit_d, limit_q;
  logic                             out_valid_q;

  // Configuration registers; indexes past the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= ppid_pkg::TARGET_RST;
      prop_gain_q  <= ppid_pkg::PROP_RST;
      integ_gain_q <= ppid_pkg::INTEG_RST;
      deriv_gain_q <= ppid_pkg::DERIV_RST;
      windup_q     <= ppid_pkg::WINDUP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ppid_pkg::reg_idx_e'(cfg_index_i))
        ppid_pkg::REG_TARGET: target_q     <= cfg_data_i[ppid_pkg::TGT_W-1:0];
        ppid_pkg::REG_PROP:   prop_gain_q  <= cfg_data_i;
        ppid_pkg::REG_INTEG:  integ_gain_q <= cfg_data_i;
        ppid_pkg::REG_DERIV:  deriv_gain_q <= cfg_data_i;
        ppid_pkg::REG_WINDUP: windup_q     <= cfg_data_i[ppid_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  ppid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_hold_i (out_hold),
    .ready_o    (ready),
    .seq_o      (seq),
    .mac_o      (mac_ctl)
  );

  assign in_stall_o = !ready;

  // Error, clamped integrator and error difference.
  assign err_d = $signed({{(ERR_W-ppid_pkg::TGT_W){1'b0}}, target_q})
               - $signed({{(ERR_W-PRESSURE_WIDTH){meas_q[PRESSURE_WIDTH-1]}}, meas_q});

  assign integ_sum = $signed({{(SUM_W-ppid_pkg::INTEG_W){integ_q[ppid_pkg::INTEG_W-1]}},
                              integ_q})
                   + $signed({{(SUM_W-ERR_W){err_q[ERR_W-1]}}, err_q});
  assign lim_pos   = $signed({{(SUM_W-ppid_pkg::LIM_W){1'b0}}, windup_q});
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_d = lim_pos[ppid_pkg::INTEG_W-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_d = lim_neg[ppid_pkg::INTEG_W-1:0];
    end else begin
      integ_d = integ_sum[ppid_pkg::INTEG_W-1:0];
    end
  end

  assign diff_d = $signed({err_q[ERR_W-1], err_q}) - $signed({prev_q[ERR_W-1], prev_q});

  always_ff @(posedge clk_i) begin
    if (seq.load_meas) begin
      meas_q <= measured_pressure_i;
    end
    if (seq.load_err) begin
      err_q <= err_d;
    end
    if (seq.load_integ) begin
      diff_q <= diff_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (seq.load_integ) begin
      integ_q <= integ_d;
      prev_q  <= err_q;
    end
  end

  ppid_mac #(
    .B_W   (B_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mac_ctl),
    .target_i     (target_q),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .err_i        ($signed({{(B_W-ERR_W){err_q[ERR_W-1]}}, err_q})),
    .integral_i   ($signed({{(B_W-ppid_pkg::INTEG_W){integ_q[ppid_pkg::INTEG_W-1]}},
                            integ_q})),
    .diff_i       ($signed({{(B_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q})),
    .acc_o        (acc)
  );

  // Limiter: a negative sum also falls under the floor.
  assign acc_wide = {{(64-ACC_W){acc[ACC_W-1]}}, acc};
  assign acc_rnd  = acc + ACC_W'(ppid_pkg::ROUND_HALF);

  always_comb begin
    if (acc_wide <= ppid_pkg::FLOOR_TEST) begin
      drive_d = ppid_pkg::FLOOR_DRIVE;
      limit_d = ppid_pkg::LIM_FLOOR;
    end else if (acc_wide > ppid_pkg::CEIL_TEST) begin
      drive_d = ppid_pkg::CEIL_DRIVE;
      limit_d = ppid_pkg::LIM_CEIL;
    end else begin
      drive_d = acc_rnd[31:16];
      limit_d = ppid_pkg::LIM_NONE;
    end
  end

  assign out_hold = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.load_out) begin
      drive_q <= drive_d;
      limit_q <= limit_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_level_o = drive_q;
  assign limit_state_o = limit_q;

endmodule

// ===== sv/ppid_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure PID multiply-accumulate unit
// One shared signed multiplier with a registered product and a Q32 accumulator.
// ----------------------------------------------------------------------------
module ppid_mac #(
  parameter int B_W   = 19,
  parameter int ACC_W = 53
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppid_pkg::mac_ctl_t            ctl_i,
  input  logic [ppid_pkg::TGT_W-1:0]    target_i,
  input  logic [ppid_pkg::GAIN_W-1:0]   prop_gain_i,
  input  logic [ppid_pkg::GAIN_W-1:0]   integ_gain_i,
  input  logic [ppid_pkg::GAIN_W-1:0]   deriv_gain_i,
  input  logic signed [B_W-1:0]         err_i,
  input  logic signed [B_W-1:0]         integral_i,
  input  logic signed [B_W-1:0]         diff_i,
  output logic signed [ACC_W-1:0]       acc_o
);

  localparam int PROD_W = ppid_pkg::GAIN_W + 1 + B_W;

  logic [ppid_pkg::GAIN_W-1:0] a_sel;
  logic signed [B_W-1:0]       b_sel;
  logic signed [B_W-1:0]       tgt_b;
  logic signed [PROD_W-1:0]    prod_d;
  logic signed [PROD_W-1:0]    prod_q;
  ppid_pkg::mac_op_e           prod_op_q;
  logic                        prod_vld_q;
  logic signed [B_W-1:0]       tsq_q;
  logic signed [ACC_W-1:0]     prod_ext;
  logic signed [ACC_W-1:0]     acc_q;

  assign tgt_b = $signed({{(B_W-ppid_pkg::TGT_W){1'b0}}, target_i});

  always_comb begin
    case (ctl_i.op)
      ppid_pkg::OP_TSQ: begin
        a_sel = {{(ppid_pkg::GAIN_W-ppid_pkg::TGT_W){1'b0}}, target_i};
        b_sel = tgt_b;
      end
      ppid_pkg::OP_PROP: begin
        a_sel = prop_gain_i;
        b_sel = err_i;
      end
      ppid_pkg::OP_INTEG: begin
        a_sel = integ_gain_i;
        b_sel = integral_i;
      end
      ppid_pkg::OP_DERIV: begin
        a_sel = deriv_gain_i;
        b_sel = diff_i;
      end
      ppid_pkg::OP_BIAS1: begin
        a_sel = ppid_pkg::BIAS_C1;
        b_sel = tgt_b;
      end
      ppid_pkg::OP_BIAS2: begin
        a_sel = ppid_pkg::BIAS_C2;
        b_sel = tsq_q;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  assign prod_d   = $signed({1'b0, a_sel}) * b_sel;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    prod_op_q <= ctl_i.op;
    if (prod_vld_q && (prod_op_q == ppid_pkg::OP_TSQ)) begin
      tsq_q <= prod_q[B_W-1:0];
    end
  end

  // The gain terms are Q0.24 times an integer, so they move up by eight into Q32.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= ACC_W'(ppid_pkg::BIAS_C0);
    end else if (prod_vld_q) begin
      case (prod_op_q) inside
        ppid_pkg::OP_PROP, ppid_pkg::OP_INTEG, ppid_pkg::OP_DERIV: begin
          acc_q <= acc_q + (prod_ext <<< ppid_pkg::GAIN_SHIFT);
        end
        ppid_pkg::OP_BIAS1: begin
          acc_q <= acc_q + prod_ext;
        end
        ppid_pkg::OP_BIAS2: begin
          acc_q <= acc_q - prod_ext;
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== sv/ppid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure PID sequencer
// Steps one sample through error, integrator, six multiplies and the limiter.
// ----------------------------------------------------------------------------
module ppid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_hold_i,
  output logic                  ready_o,
  output ppid_pkg::seq_ctl_t    seq_o,
  output ppid_pkg::mac_ctl_t    mac_o
);

  ppid_pkg::seq_state_e state_q, state_d;
  ppid_pkg::mac_op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppid_pkg::ST_IDLE;
      op_q    <= ppid_pkg::OP_TSQ;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ppid_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ppid_pkg::ST_ERR;
        end
      end
      ppid_pkg::ST_ERR: begin
        state_d = ppid_pkg::ST_INTEG;
      end
      ppid_pkg::ST_INTEG: begin
        state_d = ppid_pkg::ST_MUL;
        op_d    = ppid_pkg::OP_TSQ;
      end
      ppid_pkg::ST_MUL: begin
        if (op_q == ppid_pkg::OP_BIAS2) begin
          state_d = ppid_pkg::ST_DRAIN;
        end else begin
          op_d = ppid_pkg::mac_op_e'(op_q + 3'd1);
        end
      end
      ppid_pkg::ST_DRAIN: begin
        state_d = ppid_pkg::ST_OUT;
      end
      ppid_pkg::ST_OUT: begin
        if (!out_hold_i) begin
          state_d = ppid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppid_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ready_o          = (state_q == ppid_pkg::ST_IDLE);
    seq_o.load_meas  = (state_q == ppid_pkg::ST_IDLE) && in_valid_i;
    seq_o.load_err   = (state_q == ppid_pkg::ST_ERR);
    seq_o.load_integ = (state_q == ppid_pkg::ST_INTEG);
    seq_o.load_out   = (state_q == ppid_pkg::ST_OUT) && !out_hold_i;
    mac_o.clear      = (state_q == ppid_pkg::ST_INTEG);
    mac_o.issue      = (state_q == ppid_pkg::ST_MUL);
    mac_o.op         = op_q;
  end

endmodule

// ===== sv/ppid_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure PID port checker
// Watches the ports of the pressure PID block and flags inconsistent results.
// ----------------------------------------------------------------------------
`include "pressure_pid_with_bias_defines.svh"

module ppid_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [ppid_pkg::DRIVE_W-1:0]     drive_level_o,
  input logic [1:0]                       limit_state_o
);

  // A word is worked on over many cycles, so the input closes after acceptance.
  `PPID_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `PPID_ASSERT_SAME(a_state_code, out_valid_o, limit_state_o != 2'd3)

  `PPID_ASSERT_SAME(a_floor_drive, out_valid_o && (limit_state_o == ppid_pkg::LIM_FLOOR),
                    drive_level_o == ppid_pkg::FLOOR_DRIVE)

  `PPID_ASSERT_SAME(a_ceil_drive, out_valid_o && (limit_state_o == ppid_pkg::LIM_CEIL),
                    drive_level_o == ppid_pkg::CEIL_DRIVE)

  `PPID_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(drive_level_o) && $stable(limit_state_o))

endmodule

bind pressure_pid_with_bias ppid_chk u_ppid_chk (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure PID controller testbench
// Runs a table of directed samples and register writes, then phases of random
// samples under varied gain, target and windup settings. A cycle-free model of
// the controller, or a table row, gives each expected drive word, and every word
// leaving the block is compared with the oldest one. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PW          = 12;
  localparam int GW          = ppid_pkg::GAIN_W;
  localparam int IW          = ppid_pkg::CFG_IDX_W;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 100;

  localparam logic [IW-1:0] REG_UNUSED = 3'd5;

  localparam longint BIAS0     = 64'sd768369649;
  localparam longint BIAS1     = 64'sd14270029;
  localparam longint BIAS2     = 64'sd18505;
  localparam longint FLOOR_Q32 = 64'sd343597383;
  localparam longint CEIL_Q32  = 64'sd4252017623;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic [ppid_pkg::DRIVE_W-1:0] drive;
    ppid_pkg::limit_e             lim;
  } drive_word_t;

  typedef struct packed {
    row_kind_e            kind;
    logic [IW-1:0]        idx;
    logic [GW-1:0]        data;
    logic signed [PW-1:0] meas;
    logic                 typed;
    drive_word_t          word;
  } row_t;

  localparam drive_word_t AT_FLOOR = '{ppid_pkg::FLOOR_DRIVE, ppid_pkg::LIM_FLOOR};
  localparam drive_word_t AT_CEIL  = '{ppid_pkg::CEIL_DRIVE, ppid_pkg::LIM_CEIL};
  localparam drive_word_t NO_WORD  = '{16'd0, ppid_pkg::LIM_NONE};

  localparam int NROWS = 32;
  localparam row_t DIRECTED [NROWS] = '{
    // Reset settings: full-scale swings saturate either way.
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd2047,  1'b1, AT_FLOOR},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,       -12'sd2048,  1'b1, AT_CEIL},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd100,   1'b1, AT_FLOOR},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd100,   1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd90,    1'b0, NO_WORD},
    // Zero gains leave the bias alone, swept over the target range.
    '{ROW_WRITE,  ppid_pkg::REG_PROP,   24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_INTEG,  24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_DERIV,  24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_TARGET, 24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_TARGET, 24'd511,      12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd511,   1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_TARGET, 24'd300,      12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd300,   1'b0, NO_WORD},
    // A zero windup limit holds the integrator at zero.
    '{ROW_WRITE,  ppid_pkg::REG_WINDUP, 24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_INTEG,  24'hFFFFFF,   12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,       -12'sd2048,  1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_PROP,   24'hFFFFFF,   12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_TARGET, 24'd0,        12'sd0,     1'b0, NO_WORD},
    // Negative drive lands on the floor; a large positive one on the cap.
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd2047,  1'b1, AT_FLOOR},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,       -12'sd2048,  1'b1, AT_CEIL},
    '{ROW_WRITE,  ppid_pkg::REG_WINDUP, 24'h007FFF,   12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_DERIV,  24'hFFFFFF,   12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,       -12'sd2048,  1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,       -12'sd2048,  1'b0, NO_WORD},
    // Shrinking the limit clamps the built-up integral on the next sample.
    '{ROW_WRITE,  ppid_pkg::REG_WINDUP, 24'd10,       12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  REG_UNUSED,           24'hABCDEF,   12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd0,     1'b0, NO_WORD},
    '{ROW_WRITE,  ppid_pkg::REG_TARGET, 24'hFFFFFF,   12'sd0,     1'b0, NO_WORD},
    '{ROW_SAMPLE, ppid_pkg::REG_TARGET, 24'd0,        12'sd511,   1'b0, NO_WORD}
  };

  logic                         clk_i;
  logic                         rst_ni              = 1'b0;
  logic                         cfg_valid_i         = 1'b0;
  logic                         cfg_ready_o;
  logic [IW-1:0]                cfg_index_i         = '0;
  logic [GW-1:0]                cfg_data_i          = '0;
  logic                         in_valid_i          = 1'b0;
  logic                         in_stall_o;
  logic signed [PW-1:0]         measured_pressure_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i         = 1'b0;
  logic [ppid_pkg::DRIVE_W-1:0] drive_level_o;
  logic [1:0]                   limit_state_o;

  // Controller settings and state as the model sees them.
  logic [ppid_pkg::TGT_W-1:0] tgt_cfg    = ppid_pkg::TARGET_RST;
  logic [GW-1:0]              kp_cfg     = ppid_pkg::PROP_RST;
  logic [GW-1:0]              ki_cfg     = ppid_pkg::INTEG_RST;
  logic [GW-1:0]              kd_cfg     = ppid_pkg::DERIV_RST;
  logic [ppid_pkg::LIM_W-1:0] windup_cfg = ppid_pkg::WINDUP_RST;
  logic signed [15:0]         integ_sum  = '0;
  logic signed [13:0]         last_err   = '0;

  drive_word_t pending_drives[$];
  drive_word_t head_word;
  drive_word_t typed_word;
  bit          typed_on;
  bit          calm;
  int          mismatches;
  int          quiet_cycles;

  pressure_pid_with_bias #(
    .PRESSURE_WIDTH(PW)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .measured_pressure_i(measured_pressure_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .drive_level_o      (drive_level_o),
    .limit_state_o      (limit_state_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic drive_word_t pid_drive(input logic signed [PW-1:0] p);
    longint err;
    longint acc;
    longint lim;
    longint t;
    longint sum;
    drive_word_t w;
    err = longint'(tgt_cfg) - longint'(p);
    lim = longint'(windup_cfg);
    acc = longint'(integ_sum) + err;
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    t = longint'(tgt_cfg);
    sum = longint'(kp_cfg) * err * 256 + longint'(ki_cfg) * acc * 256
        + longint'(kd_cfg) * (err - longint'(last_err)) * 256
        + BIAS0 + BIAS1 * t - BIAS2 * t * t;
    integ_sum = acc[15:0];
    last_err  = err[13:0];
    if (sum <= FLOOR_Q32) begin
      w = AT_FLOOR;
    end else if (sum > CEIL_Q32) begin
      w = AT_CEIL;
    end else begin
      sum = (sum + 64'sd32768) >>> 16;
      w.drive = sum[ppid_pkg::DRIVE_W-1:0];
      w.lim   = ppid_pkg::LIM_NONE;
    end
    return w;
  endfunction

  // Register writes and accepted samples update the model; drive words leaving
  // the block are checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ppid_pkg::REG_TARGET: tgt_cfg    = cfg_data_i[ppid_pkg::TGT_W-1:0];
          ppid_pkg::REG_PROP:   kp_cfg     = cfg_data_i;
          ppid_pkg::REG_INTEG:  ki_cfg     = cfg_data_i;
          ppid_pkg::REG_DERIV:  kd_cfg     = cfg_data_i;
          ppid_pkg::REG_WINDUP: windup_cfg = cfg_data_i[ppid_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        head_word = pid_drive(measured_pressure_i);
        pending_drives.push_back(typed_on ? typed_word : head_word);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_drives.size() == 0) begin
          mismatches++;
          $error("drive word with nothing expected: drive_level %0d, limit_state %0d",
                 drive_level_o, limit_state_o);
        end else begin
          head_word = pending_drives.pop_front();
          if (drive_level_o !== head_word.drive) begin
            mismatches++;
            $error("drive_level: expected %0d, actual %0d", head_word.drive, drive_level_o);
          end
          if (limit_state_o !== head_word.lim) begin
            mismatches++;
            $error("limit_state: expected %0d, actual %0d", head_word.lim, limit_state_o);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (rst_ni && !calm) ? ($urandom_range(0, 99) < 29) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // A write waits until every drive word in flight has come out.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [GW-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic push_sample(input logic signed [PW-1:0] p, input bit typed,
                             input drive_word_t tw);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    measured_pressure_i <= p;
    typed_on   = typed;
    typed_word = tw;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic program_phase(input int phase);
    logic [GW-1:0] tgt, kp, ki, kd, wl;
    if (phase == 1) begin
      {tgt, kp, ki, kd, wl} = '0;
    end else if (phase == 2) begin
      {tgt, kp, ki, kd, wl} = '1;
    end else if (phase % 3 == 0) begin
      tgt = GW'($urandom());
      kp  = GW'($urandom());
      ki  = GW'($urandom());
      kd  = GW'($urandom());
      wl  = GW'($urandom());
    end else begin
      // Modest gains keep most drives inside the limits.
      tgt = GW'($urandom_range(0, 511));
      kp  = GW'($urandom_range(0, 1 << 19));
      ki  = GW'($urandom_range(0, 1 << 16));
      kd  = GW'($urandom_range(0, 1 << 20));
      wl  = GW'($urandom_range(0, 2000));
    end
    write_reg(ppid_pkg::REG_WINDUP, wl);
    write_reg(ppid_pkg::REG_TARGET, tgt);
    write_reg(ppid_pkg::REG_PROP, kp);
    write_reg(ppid_pkg::REG_INTEG, ki);
    write_reg(ppid_pkg::REG_DERIV, kd);
    if ($urandom_range(0, 1)) begin
      write_reg(IW'(REG_UNUSED + $urandom_range(0, 2)), GW'($urandom()));
    end
  endtask

  initial begin
    logic signed [PW-1:0] m;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        push_sample(DIRECTED[i].meas, DIRECTED[i].typed, DIRECTED[i].word);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      calm = (phase == 5);
      program_phase(phase);
      repeat (PHASE_ITEMS) begin
        // Mostly samples close to the target, where the drive is not saturated.
        if ($urandom_range(0, 99) < 65) begin
          m = PW'(int'(tgt_cfg) + int'($urandom_range(0, 100)) - 50);
        end else begin
          m = PW'($urandom());
        end
        push_sample(m, 1'b0, NO_WORD);
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
